// File: design/uart_xon_xoff_queue_engine_macros.svh
// Assertion macros shared by the engine.
`ifndef UART_XON_XOFF_QUEUE_ENGINE_MACROS_SVH
`define UART_XON_XOFF_QUEUE_ENGINE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define UXQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define UXQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/uxq_pkg.sv
package uxq_pkg;

  localparam logic [1:0] OP_LINE = 2'd0;
  localparam logic [1:0] OP_PUT  = 2'd1;
  localparam logic [1:0] OP_GET  = 2'd2;

  localparam logic [7:0] CH_XON    = 8'h11;
  localparam logic [7:0] CH_XOFF   = 8'h13;
  localparam logic [7:0] CH_CTRL_C = 8'h03;

  localparam logic [2:0] REG_DROP_NULLS  = 3'd0;
  localparam logic [2:0] REG_HONOR_XON   = 3'd1;
  localparam logic [2:0] REG_DETECT_CC   = 3'd2;
  localparam logic [2:0] REG_RESUME_ROOM = 3'd3;
  localparam logic [2:0] REG_STOP_ROOM   = 3'd4;

  // One input item as held while it is worked on.
  typedef struct packed {
    logic [1:0] op;
    logic       framing_error;
    logic       transmit_error;
    logic       rx_ready;
    logic       tx_ready;
    logic [7:0] line_byte;
    logic [7:0] write_byte;
  } item_t;

endpackage

// File: design/uxq_ram.sv
module uxq_ram import uxq_pkg::*; #(
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/uart_xon_xoff_queue_engine.sv
// UART software flow-control queue engine.
// The input channel (in_valid / in_stall) carries one item: a line status
// event, a software put or a software get. The output channel (out_valid /
// out_stall) returns exactly one result transfer for every input transfer.
// Both rings sit in synchronous memories with registered read data.
// An accepted item is held in a register while the ring heads are read, then
// the result is computed, the state updated and the result registered.
// One item is in work at a time: a new item is not accepted until the last
// one has finished. The next item may be accepted while the result waits
// to be taken, but it completes only once the output register is free.
// When the receiver stalls, the result holds steady and new work waits.
// Reset (rst, synchronous) clears the pointers, fill counts and flags, sets
// the receive enable and loads the configuration reset values. The ring
// memories are not cleared; the fill counts never allow reading unwritten
// entries.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
module uart_xon_xoff_queue_engine import uxq_pkg::*; #(
  parameter int QUEUE_DEPTH = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic       framing_error,
  input  logic       transmit_error,
  input  logic       rx_ready,
  input  logic       tx_ready,
  input  logic [7:0] line_byte,
  input  logic [7:0] write_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       line_send_valid,
  output logic [7:0] line_send_byte,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic       put_rejected,
  output logic       break_detected,
  output logic       ctrl_c_seen,
  output logic       rx_interrupt_enable,
  output logic       tx_interrupt_enable,
  output logic [9:0] rx_level,
  output logic [9:0] tx_level,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = AW + 1;
  localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);

  logic drop_nulls, honor_xon_xoff, detect_ctrl_c;
  logic [9:0] resume_room, stop_room;

  logic [AW-1:0] rx_write_ptr, rx_read_ptr, tx_write_ptr, tx_read_ptr;
  logic [FW-1:0] rx_fill, tx_fill;
  logic sent_xoff, after_break, rx_enable, tx_enable, tx_paused, break_sticky;
  logic [7:0] pending_control;

  // busy: an item sits in the hold register waiting for the ring data and a free output register.
  logic  busy;
  item_t item;
  logic  finish;

  logic [7:0] rx_rdata, tx_rdata;
  logic rx_we, tx_we;
  logic [7:0] rx_wdata;

  assign in_stall = busy;
  assign finish   = busy && (!out_valid || !out_stall);

  uxq_ram #(.AW(AW)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_write_ptr), .wdata(rx_wdata),
    .raddr(rx_read_ptr), .rdata(rx_rdata)
  );
  uxq_ram #(.AW(AW)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_write_ptr), .wdata(item.write_byte),
    .raddr(tx_read_ptr), .rdata(tx_rdata)
  );

  // Next-state logic; memory read data are valid since the item waited in the
  // hold register and pointers only move when an item finishes.
  logic [AW-1:0] rx_write_ptr_next, rx_read_ptr_next, tx_write_ptr_next, tx_read_ptr_next;
  logic [FW-1:0] rx_fill_next, tx_fill_next, rx_free, rx_free_after;
  logic sent_xoff_next, after_break_next, rx_enable_next, tx_enable_next;
  logic tx_paused_next, break_sticky_next;
  logic [7:0] pending_control_next;
  logic send_v, read_v, rejected, ctrl_c;
  logic [7:0] send_b, read_b;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rx_free = (rx_fill >= DEPTH_F) ? '0 : DEPTH_F - rx_fill;

  always_comb begin
    rx_write_ptr_next = rx_write_ptr;
    rx_read_ptr_next  = rx_read_ptr;
    tx_write_ptr_next = tx_write_ptr;
    tx_read_ptr_next  = tx_read_ptr;
    rx_fill_next = rx_fill;
    tx_fill_next = tx_fill;
    sent_xoff_next = sent_xoff;
    after_break_next = after_break;
    rx_enable_next = rx_enable;
    tx_enable_next = tx_enable;
    tx_paused_next = tx_paused;
    break_sticky_next = break_sticky;
    pending_control_next = pending_control;
    send_v = 1'b0; read_v = 1'b0; rejected = 1'b0; ctrl_c = 1'b0;
    send_b = '0; read_b = '0;
    rx_we = 1'b0; tx_we = 1'b0;
    rx_wdata = item.line_byte;
    rx_free_after = '0;
    unique case (item.op)
      OP_LINE: begin
        if (item.framing_error) begin
          break_sticky_next = 1'b1;
          after_break_next  = 1'b1;
        end else if (item.transmit_error) begin
          tx_enable_next = 1'b0;
        end else if (pending_control != 8'h00 && item.tx_ready) begin
          send_v = 1'b1;
          send_b = pending_control;
          pending_control_next = 8'h00;
          if (tx_paused) tx_enable_next = 1'b0;
        end else if (after_break && item.rx_ready) begin
          after_break_next = 1'b0;
        end else if (item.rx_ready && rx_enable) begin
          if (!(item.line_byte == 8'h00 && drop_nulls)) begin
            if (item.line_byte == CH_CTRL_C && detect_ctrl_c) ctrl_c = 1'b1;
            if (honor_xon_xoff && item.line_byte == CH_XOFF) begin
              tx_paused_next = 1'b1;
              tx_enable_next = 1'b0;
            end else if (honor_xon_xoff && item.line_byte == CH_XON) begin
              tx_paused_next = 1'b0;
              if (tx_fill != '0) tx_enable_next = 1'b1;
            end else begin
              if (sent_xoff) begin
                if ({1'b0, rx_free} > {1'b0, resume_room}) begin
                  sent_xoff_next = 1'b0;
                  pending_control_next = CH_XON;
                end
              end else if ({1'b0, rx_free} < {1'b0, stop_room}) begin
                sent_xoff_next = 1'b1;
                pending_control_next = CH_XOFF;
              end
              if (rx_fill < DEPTH_F) begin
                rx_we = 1'b1;
                rx_write_ptr_next = advance(rx_write_ptr);
                rx_fill_next = rx_fill + 1'b1;
                if (rx_fill_next >= DEPTH_F) rx_enable_next = 1'b0;
              end
            end
          end
        end else if (item.tx_ready && tx_enable) begin
          if (tx_fill == '0) begin
            tx_enable_next = 1'b0;
          end else begin
            send_v = 1'b1;
            send_b = tx_rdata;
            tx_read_ptr_next = advance(tx_read_ptr);
            tx_fill_next = tx_fill - 1'b1;
            if (tx_fill_next == '0) tx_enable_next = 1'b0;
          end
        end
      end
      OP_PUT: begin
        if (tx_fill >= DEPTH_F) begin
          rejected = 1'b1;
        end else begin
          tx_we = 1'b1;
          tx_write_ptr_next = advance(tx_write_ptr);
          tx_fill_next = tx_fill + 1'b1;
        end
        if (!tx_paused) tx_enable_next = 1'b1;
      end
      OP_GET: begin
        if (rx_fill != '0) begin
          read_v = 1'b1;
          read_b = rx_rdata;
          rx_read_ptr_next = advance(rx_read_ptr);
          rx_fill_next = rx_fill - 1'b1;
        end
        rx_free_after = DEPTH_F - rx_fill_next;
        if (sent_xoff && {1'b0, rx_free_after} > {1'b0, resume_room}) begin
          sent_xoff_next = 1'b0;
          pending_control_next = CH_XON;
          tx_enable_next = 1'b1;
        end
        rx_enable_next = 1'b1;
      end
      default: begin
      end
    endcase
    if (!finish) begin
      rx_we = 1'b0;
      tx_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      rx_write_ptr <= '0; rx_read_ptr <= '0; rx_fill <= '0;
      tx_write_ptr <= '0; tx_read_ptr <= '0; tx_fill <= '0;
      sent_xoff <= 1'b0; after_break <= 1'b0; rx_enable <= 1'b1;
      tx_enable <= 1'b0; tx_paused <= 1'b0; break_sticky <= 1'b0;
      pending_control <= 8'h00;
      drop_nulls <= 1'b0; honor_xon_xoff <= 1'b1; detect_ctrl_c <= 1'b1;
      resume_room <= 10'd63; stop_room <= 10'd4;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DROP_NULLS:  drop_nulls <= cfg_data[0];
          REG_HONOR_XON:   honor_xon_xoff <= cfg_data[0];
          REG_DETECT_CC:   detect_ctrl_c <= cfg_data[0];
          REG_RESUME_ROOM: resume_room <= cfg_data;
          REG_STOP_ROOM:   stop_room <= cfg_data;
          default: begin
          end
        endcase
      end
      // A finishing item refills the output register in the same cycle that
      // the previous result is taken.
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_valid && !in_stall) begin
        busy <= 1'b1;
        item <= '{op, framing_error, transmit_error, rx_ready, tx_ready,
                  line_byte, write_byte};
      end
      if (finish) begin
        busy <= 1'b0;
        rx_write_ptr <= rx_write_ptr_next; rx_read_ptr <= rx_read_ptr_next;
        tx_write_ptr <= tx_write_ptr_next; tx_read_ptr <= tx_read_ptr_next;
        rx_fill <= rx_fill_next; tx_fill <= tx_fill_next;
        sent_xoff <= sent_xoff_next; after_break <= after_break_next;
        rx_enable <= rx_enable_next; tx_enable <= tx_enable_next;
        tx_paused <= tx_paused_next; break_sticky <= break_sticky_next;
        pending_control <= pending_control_next;
        line_send_valid <= send_v; line_send_byte <= send_b;
        read_valid <= read_v; read_byte <= read_b;
        put_rejected <= rejected; ctrl_c_seen <= ctrl_c;
        break_detected <= break_sticky_next;
        rx_interrupt_enable <= rx_enable_next;
        tx_interrupt_enable <= tx_enable_next;
        rx_level <= 10'(rx_fill_next);
        tx_level <= 10'(tx_fill_next);
      end
    end
  end

`include "uart_xon_xoff_queue_engine_macros.svh"

  `UXQ_ASSERT_IMP(a_rx_fill_bound, clk, rst, 1'b1, rx_fill <= DEPTH_F, "rx fill over depth")
  `UXQ_ASSERT_IMP(a_tx_fill_bound, clk, rst, 1'b1, tx_fill <= DEPTH_F, "tx fill over depth")
  `UXQ_ASSERT_NEXT(a_finish_out, clk, rst, finish, out_valid, "finished item gave no result")
  `UXQ_ASSERT_IMP(a_pending_code, clk, rst, pending_control != 8'h00, pending_control == CH_XON || pending_control == CH_XOFF, "bad pending control byte")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import uxq_pkg::*;

  localparam int DEPTH = 512;
  // Op code 3 is not used by the engine: it changes nothing and reports status.
  localparam logic [1:0] OP_IDLE = 2'd3;

  // One result transfer, packed in port order.
  typedef struct packed {
    logic       send_v;
    logic [7:0] send_b;
    logic       read_v;
    logic [7:0] read_b;
    logic       rejected;
    logic       brk;
    logic       ctrl_c;
    logic       rx_ie;
    logic       tx_ie;
    logic [9:0] rx_lvl;
    logic [9:0] tx_lvl;
  } status_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] op = OP_LINE;
  logic       framing_error = 1'b0;
  logic       transmit_error = 1'b0;
  logic       rx_ready = 1'b0;
  logic       tx_ready = 1'b0;
  logic [7:0] line_byte = 8'h00;
  logic [7:0] write_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       line_send_valid;
  logic [7:0] line_send_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       put_rejected;
  logic       break_detected;
  logic       ctrl_c_seen;
  logic       rx_interrupt_enable;
  logic       tx_interrupt_enable;
  logic [9:0] rx_level;
  logic [9:0] tx_level;
  logic       cfg_write = 1'b0;
  logic [2:0] cfg_index = REG_DROP_NULLS;
  logic [9:0] cfg_data = 10'd0;

  uart_xon_xoff_queue_engine uut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Mirror of the engine: both rings, their pointers and fills, the flow
  // control flags and the configuration registers.
  logic [7:0] rx_ring [DEPTH];
  logic [7:0] tx_ring [DEPTH];
  logic [8:0] rx_wp, rx_rp, tx_wp, tx_rp;
  int         rx_cnt, tx_cnt;
  logic       xoff_out, skip_next, rx_en, tx_en, paused, brk_seen;
  logic [7:0] ctl_waiting;
  logic       m_drop_nulls, m_honor, m_detect_cc;
  int         m_resume_room, m_stop_room;

  item_t   to_send[$];       // items waiting for the driver
  status_t status_due[$];    // predicted results, oldest first
  item_t   cur;
  int      n_queued = 0;
  int      n_taken = 0;
  int      errors = 0;
  bit      quiet = 1'b0;     // suppresses random idling on both channels

  // Step the mirror by one accepted item and return the status it reports.
  function automatic status_t flow_step(item_t it);
    status_t s;
    int      room;
    s = '0;
    room = DEPTH - rx_cnt;
    case (it.op)
      OP_LINE: begin
        if (it.framing_error) begin
          brk_seen = 1'b1;
          skip_next = 1'b1;
        end else if (it.transmit_error) begin
          tx_en = 1'b0;
        end else if (ctl_waiting != 8'h00 && it.tx_ready) begin
          s.send_v = 1'b1;
          s.send_b = ctl_waiting;
          ctl_waiting = 8'h00;
          if (paused) tx_en = 1'b0;
        end else if (skip_next && it.rx_ready) begin
          skip_next = 1'b0;
        end else if (it.rx_ready && rx_en) begin
          // Received byte: null filter, break-in flag, flow control, then ring.
          if (!(it.line_byte == 8'h00 && m_drop_nulls)) begin
            if (it.line_byte == CH_CTRL_C && m_detect_cc) s.ctrl_c = 1'b1;
            if (m_honor && it.line_byte == CH_XOFF) begin
              paused = 1'b1;
              tx_en = 1'b0;
            end else if (m_honor && it.line_byte == CH_XON) begin
              paused = 1'b0;
              if (tx_cnt > 0) tx_en = 1'b1;
            end else begin
              if (xoff_out) begin
                if (room > m_resume_room) begin
                  xoff_out = 1'b0;
                  ctl_waiting = CH_XON;
                end
              end else if (room < m_stop_room) begin
                xoff_out = 1'b1;
                ctl_waiting = CH_XOFF;
              end
              if (rx_cnt < DEPTH) begin
                rx_ring[rx_wp] = it.line_byte;
                rx_wp++;
                rx_cnt++;
                if (rx_cnt >= DEPTH) rx_en = 1'b0;
              end
            end
          end
        end else if (it.tx_ready && tx_en) begin
          if (tx_cnt == 0) begin
            tx_en = 1'b0;
          end else begin
            s.send_v = 1'b1;
            s.send_b = tx_ring[tx_rp];
            tx_rp++;
            tx_cnt--;
            if (tx_cnt == 0) tx_en = 1'b0;
          end
        end
      end
      OP_PUT: begin
        if (tx_cnt >= DEPTH) begin
          s.rejected = 1'b1;
        end else begin
          tx_ring[tx_wp] = it.write_byte;
          tx_wp++;
          tx_cnt++;
        end
        if (!paused) tx_en = 1'b1;
      end
      OP_GET: begin
        if (rx_cnt > 0) begin
          s.read_v = 1'b1;
          s.read_b = rx_ring[rx_rp];
          rx_rp++;
          rx_cnt--;
        end
        if (xoff_out && (DEPTH - rx_cnt) > m_resume_room) begin
          xoff_out = 1'b0;
          ctl_waiting = CH_XON;
          tx_en = 1'b1;
        end
        rx_en = 1'b1;
      end
      default: ;
    endcase
    s.brk = brk_seen;
    s.rx_ie = rx_en;
    s.tx_ie = tx_en;
    s.rx_lvl = rx_cnt[9:0];
    s.tx_lvl = tx_cnt[9:0];
    return s;
  endfunction

  // Driver: a new item is offered whenever the channel is free, except for
  // random idle cycles. A stalled item is held unchanged.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) status_due.push_back(flow_step(cur));
      if (!in_valid || !in_stall) begin
        if (to_send.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
          cur = to_send.pop_front();
          in_valid <= 1'b1;
          {op, framing_error, transmit_error, rx_ready, tx_ready,
           line_byte, write_byte} <= cur;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string what, input logic [9:0] want, input logic [9:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Monitor: every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_taken++;
        if (status_due.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          errors++;
        end else begin
          want = status_due.pop_front();
          report("line_send_valid", 10'(want.send_v), 10'(line_send_valid));
          report("line_send_byte", 10'(want.send_b), 10'(line_send_byte));
          report("read_valid", 10'(want.read_v), 10'(read_valid));
          report("read_byte", 10'(want.read_b), 10'(read_byte));
          report("put_rejected", 10'(want.rejected), 10'(put_rejected));
          report("break_detected", 10'(want.brk), 10'(break_detected));
          report("ctrl_c_seen", 10'(want.ctrl_c), 10'(ctrl_c_seen));
          report("rx_interrupt_enable", 10'(want.rx_ie), 10'(rx_interrupt_enable));
          report("tx_interrupt_enable", 10'(want.tx_ie), 10'(tx_interrupt_enable));
          report("rx_level", want.rx_lvl, rx_level);
          report("tx_level", want.tx_lvl, tx_level);
        end
      end
      out_stall <= !quiet && $urandom_range(99) < 12;
    end
  end

  function automatic item_t make(input logic [1:0] o, input logic fe, input logic te,
                                 input logic rxr, input logic txr,
                                 input logic [7:0] lb, input logic [7:0] wb);
    item_t it;
    it.op = o;
    it.framing_error = fe;
    it.transmit_error = te;
    it.rx_ready = rxr;
    it.tx_ready = txr;
    it.line_byte = lb;
    it.write_byte = wb;
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    to_send.push_back(it);
    n_queued++;
  endtask

  // A random item: mostly line events, with breaks kept rare so that the
  // received bytes get through, and the flow control characters frequent.
  task automatic queue_random();
    item_t it;
    int    pick;
    it = item_t'({$urandom, $urandom});
    pick = $urandom_range(99);
    it.op = (pick < 55) ? OP_LINE : (pick < 75) ? OP_PUT : (pick < 95) ? OP_GET : OP_IDLE;
    it.framing_error = ($urandom_range(99) < 4);
    it.transmit_error = ($urandom_range(99) < 8);
    case ($urandom_range(9))
      0: it.line_byte = 8'h00;
      1: it.line_byte = CH_CTRL_C;
      2: it.line_byte = CH_XON;
      3: it.line_byte = CH_XOFF;
      default: ;
    endcase
    queue_item(it);
  endtask

  // Wait until every queued item has produced its result, then let the
  // pipeline settle before touching the configuration.
  task automatic drain();
    while (n_taken < n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[9:0];
    case (idx)
      REG_DROP_NULLS:  m_drop_nulls = val[0];
      REG_HONOR_XON:   m_honor = val[0];
      REG_DETECT_CC:   m_detect_cc = val[0];
      REG_RESUME_ROOM: m_resume_room = val;
      REG_STOP_ROOM:   m_stop_room = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(input int dn, input int hx, input int dc, input int rr, input int sr);
    write_reg(REG_DROP_NULLS, dn);
    write_reg(REG_HONOR_XON, hx);
    write_reg(REG_DETECT_CC, dc);
    write_reg(REG_RESUME_ROOM, rr);
    write_reg(REG_STOP_ROOM, sr);
  endtask

  initial begin
    rx_wp = '0; rx_rp = '0; tx_wp = '0; tx_rp = '0;
    rx_cnt = 0; tx_cnt = 0;
    xoff_out = 1'b0; skip_next = 1'b0; rx_en = 1'b1; tx_en = 1'b0;
    paused = 1'b0; brk_seen = 1'b0; ctl_waiting = 8'h00;
    m_drop_nulls = 1'b0; m_honor = 1'b1; m_detect_cc = 1'b1;
    m_resume_room = 63; m_stop_room = 4;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset configuration: empty get, unused op,
    // pause and resume of transmission, ctrl-C, a kept null byte, a lost
    // clear-to-send, a break and the byte after it.
    queue_item(make(OP_GET, 0, 0, 0, 0, 8'h00, 8'h00));
    queue_item(make(OP_IDLE, 1, 1, 1, 1, 8'hFF, 8'hFF));
    queue_item(make(OP_PUT, 0, 0, 0, 0, 8'h00, 8'hFF));
    queue_item(make(OP_PUT, 0, 0, 0, 0, 8'h00, 8'h00));
    queue_item(make(OP_LINE, 0, 0, 0, 1, 8'h00, 8'h00));
    queue_item(make(OP_LINE, 0, 0, 1, 1, CH_XOFF, 8'h00));
    queue_item(make(OP_LINE, 0, 0, 0, 1, 8'h00, 8'h00));
    queue_item(make(OP_PUT, 0, 0, 0, 0, 8'h00, 8'h41));
    queue_item(make(OP_LINE, 0, 0, 1, 0, CH_XON, 8'h00));
    queue_item(make(OP_LINE, 0, 0, 1, 0, CH_CTRL_C, 8'h00));
    queue_item(make(OP_LINE, 0, 0, 1, 0, 8'h00, 8'h00));
    queue_item(make(OP_LINE, 0, 1, 1, 1, 8'h55, 8'h00));
    queue_item(make(OP_LINE, 1, 1, 1, 1, 8'hFF, 8'hFF));
    queue_item(make(OP_LINE, 0, 0, 1, 1, 8'hFF, 8'h00));
    queue_item(make(OP_LINE, 0, 0, 1, 0, 8'hFF, 8'h00));
    repeat (4) queue_item(make(OP_GET, 0, 0, 0, 0, 8'h00, 8'h00));
    repeat (4) queue_item(make(OP_LINE, 0, 0, 0, 1, 8'h00, 8'h00));
    drain();

    // Nulls dropped, flow control characters taken as data, extreme rooms.
    write_all(1, 0, 0, 0, 512);
    repeat (150) queue_random();
    drain();

    write_all(0, 1, 1, 512, 0);
    repeat (150) queue_random();
    drain();

    // Fill the receive ring past full so the engine sends XOFF, then take
    // enough bytes out that XON follows; then fill the transmit ring past
    // full and send part of it. The receive fill runs without idling on either
    // channel.
    write_all(0, 1, 1, 63, 4);
    quiet = 1'b1;
    queue_item(make(OP_LINE, 0, 0, 1, 0, CH_XON, 8'h00));
    repeat (516) queue_item(make(OP_LINE, 0, 0, 1, 0, 8'(8'h20 + $urandom_range(80)), 8'h00));
    repeat (3) queue_item(make(OP_LINE, 0, 0, 0, 1, 8'h00, 8'h00));
    drain();
    quiet = 1'b0;
    repeat (70) queue_item(make(OP_GET, 0, 0, 0, 0, 8'h00, 8'h00));
    repeat (3) queue_item(make(OP_LINE, 0, 0, 0, 1, 8'h00, 8'h00));
    repeat (515) queue_item(make(OP_PUT, 0, 0, 0, 0, 8'h00, 8'($urandom_range(255))));
    repeat (200) queue_item(make(OP_LINE, 0, 0, 0, 1, 8'h00, 8'h00));
    drain();

    write_all($urandom_range(1), $urandom_range(1), $urandom_range(1),
              $urandom_range(512), $urandom_range(512));
    repeat (200) queue_random();
    drain();

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("%0t: timeout", $time);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/uxq_pkg.sv
design/uxq_ram.sv
design/uart_xon_xoff_queue_engine.sv
test/tb_top.sv
